// File: design/cmfs_pkg.sv
// ----------------------------------------------------------------------------
// cmfs_pkg: shared types and constants for cube map face selection
// Face codes, default widths and the control group that rides the divider row.
// ----------------------------------------------------------------------------
package cmfs_pkg;

	// default direction component width and output fraction bits
	localparam int COORD_WIDTH_DEF   = 16;
	localparam int OUT_FRAC_BITS_DEF = 16;

	// cube face codes
	typedef enum logic [2:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} face_t;

	// per-item control that travels alongside the remainders
	typedef struct packed {
		face_t face;
		logic  s_neg;
		logic  t_neg;
		logic  zero;
	} cmfs_ctrl_t;

endpackage

// File: design/cmfs_front.sv
// ----------------------------------------------------------------------------
// cmfs_front: major axis selection stage
// Takes magnitudes, picks the face and hands magnitude operands to the row.
// ----------------------------------------------------------------------------
module cmfs_front
	import cmfs_pkg::*;
#(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [COORD_WIDTH-1:0]   dir_x,
	input  logic [COORD_WIDTH-1:0]   dir_y,
	input  logic [COORD_WIDTH-1:0]   dir_z,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [COORD_WIDTH-1:0]   out_ma,
	output logic [COORD_WIDTH-1:0]   out_rs,
	output logic [COORD_WIDTH-1:0]   out_rt,
	output logic [OUT_FRAC_BITS-1:0] out_qs,
	output logic [OUT_FRAC_BITS-1:0] out_qt,
	output cmfs_ctrl_t               out_ctrl
);

	logic                   x_neg, y_neg, z_neg;
	logic [COORD_WIDTH-1:0] ax, ay, az;
	logic [COORD_WIDTH-1:0] ma_d, rs_d, rt_d;
	cmfs_ctrl_t             ctrl_d;
	logic                   valid_q;
	logic [COORD_WIDTH-1:0] ma_q, rs_q, rt_q;
	cmfs_ctrl_t             ctrl_q;

	// magnitudes, most negative value maps to 2^(w-1) exactly
	assign x_neg = dir_x[COORD_WIDTH-1];
	assign y_neg = dir_y[COORD_WIDTH-1];
	assign z_neg = dir_z[COORD_WIDTH-1];
	assign ax = x_neg ? (~dir_x + 1'b1) : dir_x;
	assign ay = y_neg ? (~dir_y + 1'b1) : dir_y;
	assign az = z_neg ? (~dir_z + 1'b1) : dir_z;

	// major axis by strict compare, later axis wins ties
	always_comb begin
		ctrl_d.zero = (ax == '0) && (ay == '0) && (az == '0);
		if ((ax > ay) && (ax > az)) begin
			ma_d = ax;
			rs_d = az;
			rt_d = ay;
			ctrl_d.t_neg = !y_neg;
			if (!x_neg) begin
				ctrl_d.face  = FACE_POS_X;
				ctrl_d.s_neg = !z_neg;
			end else begin
				ctrl_d.face  = FACE_NEG_X;
				ctrl_d.s_neg = z_neg;
			end
		end else if (ay > az) begin
			ma_d = ay;
			rs_d = ax;
			rt_d = az;
			ctrl_d.s_neg = x_neg;
			if (!y_neg) begin
				ctrl_d.face  = FACE_POS_Y;
				ctrl_d.t_neg = z_neg;
			end else begin
				ctrl_d.face  = FACE_NEG_Y;
				ctrl_d.t_neg = !z_neg;
			end
		end else begin
			ma_d = az;
			rs_d = ax;
			rt_d = ay;
			ctrl_d.t_neg = !y_neg;
			if (!z_neg) begin
				ctrl_d.face  = FACE_POS_Z;
				ctrl_d.s_neg = x_neg;
			end else begin
				ctrl_d.face  = FACE_NEG_Z;
				ctrl_d.s_neg = !x_neg;
			end
		end
	end

	assign in_ready = !valid_q || out_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ma_q   <= ma_d;
			rs_q   <= rs_d;
			rt_q   <= rt_d;
			ctrl_q <= ctrl_d;
		end
	end

	assign out_valid = valid_q;
	assign out_ma    = ma_q;
	assign out_rs    = rs_q;
	assign out_rt    = rt_q;
	assign out_qs    = '0;
	assign out_qt    = '0;
	assign out_ctrl  = ctrl_q;

endmodule

// File: design/cmfs_cell.sv
// ----------------------------------------------------------------------------
// cmfs_cell: one restoring divide cell
// Resolves one quotient bit for both face coordinates and passes the item on.
// ----------------------------------------------------------------------------
module cmfs_cell
	import cmfs_pkg::*;
#(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [COORD_WIDTH-1:0]   in_ma,
	input  logic [COORD_WIDTH-1:0]   in_rs,
	input  logic [COORD_WIDTH-1:0]   in_rt,
	input  logic [OUT_FRAC_BITS-1:0] in_qs,
	input  logic [OUT_FRAC_BITS-1:0] in_qt,
	input  cmfs_ctrl_t               in_ctrl,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [COORD_WIDTH-1:0]   out_ma,
	output logic [COORD_WIDTH-1:0]   out_rs,
	output logic [COORD_WIDTH-1:0]   out_rt,
	output logic [OUT_FRAC_BITS-1:0] out_qs,
	output logic [OUT_FRAC_BITS-1:0] out_qt,
	output cmfs_ctrl_t               out_ctrl
);

	logic                     bit_s, bit_t;
	logic [COORD_WIDTH-1:0]   sub_s, sub_t;
	logic                     valid_q;
	logic [COORD_WIDTH-1:0]   ma_q, rs_q, rt_q;
	logic [OUT_FRAC_BITS-1:0] qs_q, qt_q;
	cmfs_ctrl_t               ctrl_q;

	// trial subtract, partial remainder stays below the divisor afterward
	assign bit_s = in_rs >= in_ma;
	assign bit_t = in_rt >= in_ma;
	assign sub_s = bit_s ? (in_rs - in_ma) : in_rs;
	assign sub_t = bit_t ? (in_rt - in_ma) : in_rt;

	assign in_ready = !valid_q || out_ready;

	// cell valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// shifted remainders and quotient bits move to the next cell
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ma_q   <= in_ma;
			rs_q   <= {sub_s[COORD_WIDTH-2:0], 1'b0};
			rt_q   <= {sub_t[COORD_WIDTH-2:0], 1'b0};
			qs_q   <= {in_qs[OUT_FRAC_BITS-2:0], bit_s};
			qt_q   <= {in_qt[OUT_FRAC_BITS-2:0], bit_t};
			ctrl_q <= in_ctrl;
		end
	end

	assign out_valid = valid_q;
	assign out_ma    = ma_q;
	assign out_rs    = rs_q;
	assign out_rt    = rt_q;
	assign out_qs    = qs_q;
	assign out_qt    = qt_q;
	assign out_ctrl  = ctrl_q;

endmodule

// File: design/cmfs_back.sv
// ----------------------------------------------------------------------------
// cmfs_back: coordinate assembly and output register
// Applies the sign around one half and packs the result item.
// ----------------------------------------------------------------------------
module cmfs_back
	import cmfs_pkg::*;
#(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
	parameter int TDATA_WIDTH   = 40
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OUT_FRAC_BITS-1:0] in_qs,
	input  logic [OUT_FRAC_BITS-1:0] in_qt,
	input  cmfs_ctrl_t               in_ctrl,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [TDATA_WIDTH-1:0]   m_tdata
);

	localparam int CW = OUT_FRAC_BITS + 1;
	localparam logic [CW-1:0] HALF = {2'b01, {(OUT_FRAC_BITS - 1){1'b0}}};

	logic [CW-1:0]          cs_d, ct_d;
	logic                   valid_q;
	logic [TDATA_WIDTH-1:0] data_q;

	// coord = half +/- quotient, fixed at half for the zero vector
	always_comb begin
		if (in_ctrl.zero) begin
			cs_d = HALF;
			ct_d = HALF;
		end else begin
			cs_d = in_ctrl.s_neg ? (HALF - {1'b0, in_qs}) : (HALF + {1'b0, in_qs});
			ct_d = in_ctrl.t_neg ? (HALF - {1'b0, in_qt}) : (HALF + {1'b0, in_qt});
		end
	end

	assign in_ready = !valid_q || m_tready;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// output item
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= TDATA_WIDTH'({in_ctrl.zero, ct_d, cs_d, in_ctrl.face});
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

// File: design/cube_map_face_select_core.sv
// throughput: one item per cycle while m_tready is high, set by a row of
// OUT_FRAC_BITS divide cells each resolving one quotient bit, plus one
// select stage and one output stage
// every stage holds its item while the next one is full, so bubbles close up
// reset: arst_n clears all valid flags at once, payload registers keep junk
// ----------------------------------------------------------------------------
// cube_map_face_select_core: cube map face and face coordinate unit
// Picks the major axis face of a direction and divides out s and t.
// ----------------------------------------------------------------------------
module cube_map_face_select_core
	import cmfs_pkg::*;
#(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
	localparam int S_TDATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8,
	localparam int M_TDATA_WIDTH = ((2 * OUT_FRAC_BITS + 6 + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// dir_x, dir_y, dir_z (low to high), zero padded
	input  logic [S_TDATA_WIDTH-1:0] s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// face, coord_s, coord_t, zero_vector (low to high), zero padded
	output logic [M_TDATA_WIDTH-1:0] m_tdata
);

	localparam int W = COORD_WIDTH;
	localparam int F = OUT_FRAC_BITS;

	logic         valid [F+1];
	logic         ready [F+1];
	logic [W-1:0] ma    [F+1];
	logic [W-1:0] rs    [F+1];
	logic [W-1:0] rt    [F+1];
	logic [F-1:0] qs    [F+1];
	logic [F-1:0] qt    [F+1];
	cmfs_ctrl_t   ctrl  [F+1];

	// axis select stage
	cmfs_front #(
		.COORD_WIDTH  (W),
		.OUT_FRAC_BITS(F)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.dir_x    (s_tdata[W-1:0]),
		.dir_y    (s_tdata[2*W-1:W]),
		.dir_z    (s_tdata[3*W-1:2*W]),
		.out_valid(valid[0]),
		.out_ready(ready[0]),
		.out_ma   (ma[0]),
		.out_rs   (rs[0]),
		.out_rt   (rt[0]),
		.out_qs   (qs[0]),
		.out_qt   (qt[0]),
		.out_ctrl (ctrl[0])
	);

	// divide row, most significant quotient bit first
	for (genvar i = 0; i < F; i++) begin : g_cell
		cmfs_cell #(
			.COORD_WIDTH  (W),
			.OUT_FRAC_BITS(F)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid[i]),
			.in_ready (ready[i]),
			.in_ma    (ma[i]),
			.in_rs    (rs[i]),
			.in_rt    (rt[i]),
			.in_qs    (qs[i]),
			.in_qt    (qt[i]),
			.in_ctrl  (ctrl[i]),
			.out_valid(valid[i+1]),
			.out_ready(ready[i+1]),
			.out_ma   (ma[i+1]),
			.out_rs   (rs[i+1]),
			.out_rt   (rt[i+1]),
			.out_qs   (qs[i+1]),
			.out_qt   (qt[i+1]),
			.out_ctrl (ctrl[i+1])
		);
	end

	// output stage, last remainders and divisor are dropped
	cmfs_back #(
		.OUT_FRAC_BITS(F),
		.TDATA_WIDTH  (M_TDATA_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(valid[F]),
		.in_ready(ready[F]),
		.in_qs   (qs[F]),
		.in_qt   (qt[F]),
		.in_ctrl (ctrl[F]),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

// File: design/cmfs_checker.sv
// ----------------------------------------------------------------------------
// cmfs_props: port level checks for the face select core
// Watches the result stream for held items and legal face and coord values.
// ----------------------------------------------------------------------------
module cmfs_props
	import cmfs_pkg::*;
#(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
	parameter int TDATA_WIDTH   = 40
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [TDATA_WIDTH-1:0] m_tdata
);

	localparam int CW = OUT_FRAC_BITS + 1;
	localparam logic [CW-1:0] HALF = {2'b01, {(OUT_FRAC_BITS - 1){1'b0}}};
	localparam logic [CW-1:0] ONE  = {1'b1, {OUT_FRAC_BITS{1'b0}}};

	logic [2:0]    face;
	logic [CW-1:0] coord_s, coord_t;
	logic          zero_vector;

	assign face        = m_tdata[2:0];
	assign coord_s     = m_tdata[CW+2:3];
	assign coord_t     = m_tdata[2*CW+2:CW+3];
	assign zero_vector = m_tdata[2*CW+3];

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// face code in range
	a_face: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (face != 3'd6) && (face != 3'd7))
		else $error("face code out of range");

	// coords never pass 1.0
	a_coord: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (coord_s <= ONE) && (coord_t <= ONE))
		else $error("face coordinate above one");

	// zero vector gives +z face at the center
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && zero_vector |->
			(face == FACE_POS_Z) && (coord_s == HALF) && (coord_t == HALF))
		else $error("zero vector result malformed");

endmodule

bind cube_map_face_select_core cmfs_props #(
	.OUT_FRAC_BITS(OUT_FRAC_BITS),
	.TDATA_WIDTH  (M_TDATA_WIDTH)
) u_cmfs_props (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// File: bench/cmfs_checker.sv
// ----------------------------------------------------------------------------
// cmfs_checker: face selection predictor and result scoreboard
// Watches both stream channels of the face select core. Every accepted
// direction is turned into its expected face, s, t and zero flag; every
// accepted result is compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module cmfs_checker
	import cmfs_pkg::*;
#(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
	parameter int S_W           = ((3 * COORD_WIDTH + 7) / 8) * 8,
	parameter int M_W           = ((2 * OUT_FRAC_BITS + 6 + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic           s_tready,
	// dir_x, dir_y, dir_z (low to high), zero padded
	input  logic [S_W-1:0] s_tdata,
	input  logic           m_tvalid,
	input  logic           m_tready,
	// face, coord_s, coord_t, zero_vector (low to high), zero padded
	input  logic [M_W-1:0] m_tdata,
	output int             fail_count,
	output int             pending
);

	localparam int CO_W   = OUT_FRAC_BITS + 1;
	localparam int S_LO   = 3;
	localparam int T_LO   = S_LO + CO_W;
	localparam int ZV_BIT = T_LO + CO_W;
	localparam int PAD_LO = ZV_BIT + 1;

	typedef struct {
		face_t           face;
		logic [CO_W-1:0] coord_s;
		logic [CO_W-1:0] coord_t;
		logic            zero_vector;
	} face_result_t;

	face_result_t face_due[$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// (num / den + 1) / 2 in output fixed point, quotient truncated toward zero
	function automatic logic [CO_W-1:0] face_coord_of(longint num, longint den);
		longint half;
		longint q;
		half = longint'(1) << (OUT_FRAC_BITS - 1);
		q = (num * half) / den + half;
		if (q < 0)
			q = 0;
		if (q > 2 * half)
			q = 2 * half;
		return q[CO_W-1:0];
	endfunction

	// major axis face and face coordinates of one direction
	function automatic face_result_t face_lookup(logic [S_W-1:0] data);
		logic signed [COORD_WIDTH-1:0] rx, ry, rz;
		longint x, y, z, ax, ay, az, sc, tc, ma, half;
		face_result_t r;
		rx = data[0 +: COORD_WIDTH];
		ry = data[COORD_WIDTH +: COORD_WIDTH];
		rz = data[2 * COORD_WIDTH +: COORD_WIDTH];
		x = longint'(rx);
		y = longint'(ry);
		z = longint'(rz);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		half = longint'(1) << (OUT_FRAC_BITS - 1);
		// zero vector: no division, centre of the +z face
		if (ax == 0 && ay == 0 && az == 0) begin
			r.face        = FACE_POS_Z;
			r.coord_s     = half[CO_W-1:0];
			r.coord_t     = half[CO_W-1:0];
			r.zero_vector = 1'b1;
			return r;
		end
		// strict compares: ties go to the later axis
		if (ax > ay && ax > az) begin
			if (x >= 0) begin
				sc = -z;
				r.face = FACE_POS_X;
			end else begin
				sc = z;
				r.face = FACE_NEG_X;
			end
			tc = -y;
			ma = ax;
		end else if (ay > az) begin
			if (y >= 0) begin
				tc = z;
				r.face = FACE_POS_Y;
			end else begin
				tc = -z;
				r.face = FACE_NEG_Y;
			end
			sc = x;
			ma = ay;
		end else begin
			if (z >= 0) begin
				sc = x;
				r.face = FACE_POS_Z;
			end else begin
				sc = -x;
				r.face = FACE_NEG_Z;
			end
			tc = -y;
			ma = az;
		end
		r.coord_s     = face_coord_of(sc, ma);
		r.coord_t     = face_coord_of(tc, ma);
		r.zero_vector = 1'b0;
		return r;
	endfunction

	// predict on input accept, compare on output accept
	always @(posedge clk) begin
		face_result_t exp_r;
		logic [2:0]      got_face;
		logic [CO_W-1:0] got_s, got_t;
		logic            got_zv;
		logic [M_W-1:0]  got_pad;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				face_due.push_back(face_lookup(s_tdata));
			if (m_tvalid && m_tready) begin
				got_face = m_tdata[2:0];
				got_s    = m_tdata[S_LO +: CO_W];
				got_t    = m_tdata[T_LO +: CO_W];
				got_zv   = m_tdata[ZV_BIT];
				got_pad  = m_tdata >> PAD_LO;
				if (face_due.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result item: face %0d s %0d t %0d zero %0b",
							got_face, got_s, got_t, got_zv);
					fail_count = fail_count + 1;
				end else begin
					exp_r = face_due.pop_front();
					if (got_face != exp_r.face || got_s != exp_r.coord_s ||
						got_t != exp_r.coord_t || got_zv != exp_r.zero_vector ||
						got_pad != '0) begin
						if (fail_count < 10)
							$display("mismatch: expected face %0d s %0d t %0d zero %0b, got face %0d s %0d t %0d zero %0b pad %0h",
								exp_r.face, exp_r.coord_s, exp_r.coord_t,
								exp_r.zero_vector, got_face, got_s, got_t, got_zv,
								got_pad);
						fail_count = fail_count + 1;
					end
				end
			end
			pending = face_due.size();
		end
	end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the cube map face select core
// Drives directed and random directions in bursts with gaps, stalls the
// result side on a changing pattern, and lets the checker score the results.
// ----------------------------------------------------------------------------
module tb_top;
	import cmfs_pkg::*;

	localparam int CW  = COORD_WIDTH_DEF;
	localparam int OFB = OUT_FRAC_BITS_DEF;
	localparam int S_W = ((3 * CW + 7) / 8) * 8;
	localparam int M_W = ((2 * OFB + 6 + 7) / 8) * 8;
	localparam int N_RANDOM  = 1400;
	localparam int TAIL_WAIT = OFB + 24;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_TIGHT,
		RX_STRIDE
	} rx_mode_t;

	logic           clk      = 1'b0;
	logic           arst_n   = 1'b0;
	logic           s_tvalid = 1'b0;
	logic           s_tready;
	logic [S_W-1:0] s_tdata  = '0;
	logic           m_tvalid;
	logic           m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;
	int             fail_count;
	int             pending;

	rx_mode_t       rx_mode = RX_OPEN;
	int unsigned    rx_left = 0;

	always #5 clk = ~clk;

	cube_map_face_select_core #(
		.COORD_WIDTH   (CW),
		.OUT_FRAC_BITS (OFB)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	cmfs_checker #(
		.COORD_WIDTH   (CW),
		.OUT_FRAC_BITS (OFB),
		.S_W           (S_W),
		.M_W           (M_W)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic logic [S_W-1:0] pack_dir(int x, int y, int z);
		logic [S_W-1:0] d;
		d = '0;
		d[0 +: CW]      = x[CW-1:0];
		d[CW +: CW]     = y[CW-1:0];
		d[2 * CW +: CW] = z[CW-1:0];
		return d;
	endfunction

	// one of a few boundary values of a component
	function automatic int edge_val();
		case ($urandom_range(0, 6))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			5: return 32766;
			default: return 32767;
		endcase
	endfunction

	// random direction, shaped toward ties, dominant axes and extremes
	function automatic logic [S_W-1:0] random_dir();
		int c[3];
		int m;
		int a;
		int i;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				for (i = 0; i < 3; i++)
					c[i] = int'($urandom_range(0, 65535));
			end
			3: begin
				for (i = 0; i < 3; i++)
					c[i] = int'($urandom_range(0, 8)) - 4;
			end
			4: begin
				for (i = 0; i < 3; i++)
					c[i] = edge_val();
			end
			5: begin
				// equal magnitudes on two or three axes
				m = int'($urandom_range(0, 32768));
				for (i = 0; i < 3; i++)
					c[i] = $urandom_range(0, 1) ? m : -m;
				a = int'($urandom_range(0, 3));
				if (a < 3)
					c[a] = int'($urandom_range(0, 65535));
			end
			6: begin
				if ($urandom_range(0, 2) == 0) begin
					c[0] = 0;
					c[1] = 0;
					c[2] = 0;
				end else begin
					for (i = 0; i < 3; i++)
						c[i] = int'($urandom_range(0, 65535));
				end
			end
			default: begin
				// one dominant axis, the others inside its magnitude
				m = int'($urandom_range(1, 32768));
				a = int'($urandom_range(0, 2));
				for (i = 0; i < 3; i++)
					c[i] = int'($urandom_range(0, 2 * m)) - m;
				c[a] = $urandom_range(0, 1) ? m : -m;
			end
		endcase
		return pack_dir(c[0], c[1], c[2]);
	endfunction

	// result side: stall pattern whose mode is redrawn whenever its countdown runs out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_mode  <= RX_OPEN;
			rx_left  <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(20, 200);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= $urandom_range(0, 1);
				RX_TIGHT:  m_tready <= ($urandom_range(0, 3) == 0);
				RX_STRIDE: m_tready <= (rx_left[2:0] != 3'd0);
			endcase
		end
	end

	// stimulus, drain and verdict
	initial begin : stimulus
		logic [S_W-1:0] dir_list[$];
		int unsigned    burst_left;
		int unsigned    gap;
		int             n_directed;
		int             idx;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero vector, each face, extremes, ties, most negative
		dir_list.push_back(pack_dir(0, 0, 0));
		dir_list.push_back(pack_dir(32767, 0, 0));
		dir_list.push_back(pack_dir(-32768, 0, 0));
		dir_list.push_back(pack_dir(0, 32767, 0));
		dir_list.push_back(pack_dir(0, -32768, 0));
		dir_list.push_back(pack_dir(0, 0, 32767));
		dir_list.push_back(pack_dir(0, 0, -32768));
		dir_list.push_back(pack_dir(100, 100, 0));
		dir_list.push_back(pack_dir(100, 0, 100));
		dir_list.push_back(pack_dir(0, -100, 100));
		dir_list.push_back(pack_dir(100, 100, 100));
		dir_list.push_back(pack_dir(-100, 100, -100));
		dir_list.push_back(pack_dir(-32768, -32768, -32768));
		dir_list.push_back(pack_dir(-32768, 32767, 32767));
		dir_list.push_back(pack_dir(32767, -32767, -32767));
		dir_list.push_back(pack_dir(32767, -32767, 32766));
		dir_list.push_back(pack_dir(-32767, 32766, -32766));
		dir_list.push_back(pack_dir(1, 0, 0));
		dir_list.push_back(pack_dir(-1, 0, 0));
		dir_list.push_back(pack_dir(0, 0, -1));
		dir_list.push_back(pack_dir(1, -1, 0));
		dir_list.push_back(pack_dir(5, 3, -32768));
		dir_list.push_back(pack_dir(-32768, 32767, -32768));
		dir_list.push_back(pack_dir(-1, -1, -1));
		n_directed = dir_list.size();
		for (idx = 0; idx < N_RANDOM; idx++)
			dir_list.push_back(random_dir());

		burst_left = 0;
		for (idx = 0; idx < dir_list.size(); idx++) begin
			if (idx == n_directed || (idx > n_directed && $urandom_range(0, 299) == 0)) begin
				// hold off until every outstanding result is out
				s_tvalid <= 1'b0;
				@(negedge clk);
				while (pending != 0)
					@(negedge clk);
				@(posedge clk);
			end else if (burst_left == 0) begin
				if ($urandom_range(0, 7) == 0)
					burst_left = $urandom_range(50, 300);
				else
					burst_left = $urandom_range(1, 12);
				case ($urandom_range(0, 5))
					0: gap = 0;
					1: gap = $urandom_range(10, 30);
					default: gap = $urandom_range(1, 5);
				endcase
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			if (burst_left > 0)
				burst_left = burst_left - 1;
			s_tvalid <= 1'b1;
			s_tdata  <= dir_list[idx];
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
		end
		s_tvalid <= 1'b0;

		// drain, then give stray results time to show up
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
design/cmfs_pkg.sv
design/cmfs_front.sv
design/cmfs_cell.sv
design/cmfs_back.sv
design/cube_map_face_select_core.sv
design/cmfs_checker.sv
bench/cmfs_checker.sv
bench/tb_top.sv
